[hdl/bfha_pkg.sv]
// ----------------------------------------------------------------------------
// bfha_pkg
// Shared types and constants for the best-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfha_pkg;

   localparam int HEAP_BYTES_DEF = 4096;
   localparam int PAGE_BYTES_DEF = 256;
   localparam int REGION_W       = 13;
   localparam logic [REGION_W-1:0] REGION_RESET = 13'd4096;

   typedef enum logic [1:0] {
      REQ_ALLOC = 2'd0,
      REQ_FREE  = 2'd1,
      REQ_INIT  = 2'd2,
      REQ_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] alloc_bytes;
      logic [11:0] free_addr;
   } req_type;

   typedef struct packed {
      logic        fail;
      logic [11:0] result_addr;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_INIT_HDR,
      S_INIT_END,
      S_INIT_FOOT,
      S_AWALK_RD,
      S_AWALK_EV,
      S_AFIN,
      S_ASPLIT,
      S_AFOOT,
      S_AEXACT,
      S_FWALK_RD,
      S_FWALK_EV,
      S_FPREV_RD,
      S_FPREV_EV,
      S_FNEXT_RD,
      S_FNEXT_EV,
      S_FSTART_RD,
      S_FSTART_EV,
      S_FHDR,
      S_FFOOT,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

[hdl/best_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// best_fit_heap_allocator
// Best-fit allocator over an implicit block list kept in one word memory.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries one request: allocate, free or init.
//   rsp channel (valid/ready) returns one response per request: fail flag
//   and the payload offset of an allocated block.
//   csr_we/csr_wdata set the region size used by the next init request.
// Init writes the header, end marker and footer; unknown or rejected
//   requests go straight to the response. Allocate and free walk the block
//   list through the single memory port, reading then evaluating each block
//   visited, then update headers and footers.
// One request is in flight at a time; req_ready is high only when idle.
// Reset clears the ready flag, the heap limit and the response valid flag;
//   the heap memory itself is not cleared, init formats what it needs.
// A stalled rsp_ready holds the response; the next finished request waits
//   until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_heap_allocator #(
   parameter int HEAP_BYTES = bfha_pkg::HEAP_BYTES_DEF,
   parameter int PAGE_BYTES = bfha_pkg::PAGE_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire bfha_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output bfha_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [bfha_pkg::REGION_W-1:0] csr_wdata
);

   localparam int WORDS  = HEAP_BYTES / 4;
   localparam int WAW    = $clog2(WORDS);
   localparam int ADDR_W = $clog2(HEAP_BYTES) + 2;
   localparam int CW     = (ADDR_W > 17) ? ADDR_W : 17;
   // page rounding by reciprocal multiply, exact for 14-bit sums
   localparam int RSH    = 14 + $clog2(PAGE_BYTES);
   localparam int RMUL   = ((1 << RSH) + PAGE_BYTES - 1) / PAGE_BYTES;

   logic [31:0] mem [WORDS];

   bfha_pkg::state_type state_ff, state_in;
   logic [bfha_pkg::REGION_W-1:0] csr_ff;
   logic              ready_ff, ready_in;
   logic [ADDR_W-1:0] limit_ff, limit_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] best_ff, best_in;
   logic [ADDR_W-1:0] bsz_ff, bsz_in;
   logic              found_ff, found_in;
   logic              prev_ff, prev_in;
   logic              bprev_ff, bprev_in;
   logic [CW-1:0]     need_ff, need_in;
   logic [ADDR_W-1:0] tgt_ff, tgt_in;
   logic [ADDR_W-1:0] size_ff, size_in;
   logic              hbit_ff, hbit_in;
   logic [ADDR_W-1:0] start_ff, start_in;
   logic [ADDR_W-1:0] total_ff, total_in;
   logic              rfail_ff, rfail_in;
   logic [11:0]       raddr_ff, raddr_in;
   logic              rsp_valid_ff;
   bfha_pkg::rsp_type rsp_ff;

   logic [31:0]       rd_q;
   logic              rd_oob_ff;
   logic [31:0]       rd_val;
   logic [ADDR_W-1:0] hsize;

   logic              mem_re, mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [31:0]       mem_wdata;
   logic              mem_in_range;

   logic [13:0]       rnd_sum;
   logic [31:0]       rnd_prod;
   logic [31:0]       rnd_pages;
   logic [31:0]       rounded;
   logic [ADDR_W-1:0] rem;
   logic [ADDR_W-1:0] nsize;
   logic              accept;
   logic              rsp_free;

   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rd_val    = rd_oob_ff ? 32'd0 : rd_q;
   assign hsize     = {rd_val[ADDR_W-1:2], 2'b00};
   assign rnd_sum   = 14'(32'(csr_ff) + 32'(PAGE_BYTES - 1));
   assign rnd_prod  = 32'(rnd_sum) * 32'(RMUL);
   assign rnd_pages = rnd_prod >> RSH;
   assign rounded   = rnd_pages * 32'(PAGE_BYTES);
   assign rem       = bsz_ff - need_ff[ADDR_W-1:0];
   assign nsize     = {rd_val[ADDR_W-1:2], 2'b00};
   assign mem_in_range = (32'(mem_addr) < 32'(HEAP_BYTES));

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      limit_in = limit_ff;
      addr_in  = addr_ff;
      best_in  = best_ff;
      bsz_in   = bsz_ff;
      found_in = found_ff;
      prev_in  = prev_ff;
      bprev_in = bprev_ff;
      need_in  = need_ff;
      tgt_in   = tgt_ff;
      size_in  = size_ff;
      hbit_in  = hbit_ff;
      start_in = start_ff;
      total_in = total_ff;
      rfail_in = rfail_ff;
      raddr_in = raddr_ff;
      unique case (state_ff)
         bfha_pkg::S_IDLE: begin
            if (accept) begin
               rfail_in = 1'b1;
               raddr_in = 12'd0;
               addr_in  = ADDR_W'(4);
               found_in = 1'b0;
               prev_in  = 1'b1;
               bprev_in = 1'b1;
               state_in = bfha_pkg::S_RESP;
               priority case (req_data.req_type)
                  bfha_pkg::REQ_INIT: begin
                     if (!ready_ff && csr_ff != '0 && rounded <= 32'(HEAP_BYTES)
                           && rounded >= 32'd8) begin
                        ready_in = 1'b1;
                        limit_in = rounded[ADDR_W-1:0];
                        size_in  = ADDR_W'(rounded - 32'd8);
                        state_in = bfha_pkg::S_INIT_HDR;
                     end
                  end
                  bfha_pkg::REQ_ALLOC: begin
                     need_in = (CW'(req_data.alloc_bytes) + CW'(11)) & ~CW'(7);
                     if (ready_ff && req_data.alloc_bytes != 16'd0)
                        state_in = bfha_pkg::S_AWALK_RD;
                  end
                  bfha_pkg::REQ_FREE: begin
                     tgt_in = ADDR_W'(req_data.free_addr) - ADDR_W'(4);
                     if (ready_ff && req_data.free_addr != 12'd0
                           && req_data.free_addr[2:0] == 3'd0)
                        state_in = bfha_pkg::S_FWALK_RD;
                  end
                  default: ;
               endcase
            end
         end
         bfha_pkg::S_INIT_HDR:  state_in = bfha_pkg::S_INIT_END;
         bfha_pkg::S_INIT_END:  state_in = bfha_pkg::S_INIT_FOOT;
         bfha_pkg::S_INIT_FOOT: begin
            rfail_in = 1'b0;
            state_in = bfha_pkg::S_RESP;
         end
         bfha_pkg::S_AWALK_RD: begin
            if ((ADDR_W+1)'(addr_ff) + (ADDR_W+1)'(4) <= (ADDR_W+1)'(limit_ff))
               state_in = bfha_pkg::S_AWALK_EV;
            else
               state_in = bfha_pkg::S_AFIN;
         end
         bfha_pkg::S_AWALK_EV: begin
            if (hsize == '0) begin
               state_in = bfha_pkg::S_AFIN;
            end else begin
               if (rd_val[0]) begin
                  prev_in = 1'b1;
               end else begin
                  if (CW'(hsize) >= need_ff && (!found_ff || hsize < bsz_ff)) begin
                     found_in = 1'b1;
                     best_in  = addr_ff;
                     bsz_in   = hsize;
                     bprev_in = prev_ff;
                  end
                  prev_in = 1'b0;
               end
               addr_in  = addr_ff + hsize;
               state_in = bfha_pkg::S_AWALK_RD;
            end
         end
         bfha_pkg::S_AFIN: begin
            if (found_ff) state_in = bfha_pkg::S_ASPLIT;
            else          state_in = bfha_pkg::S_RESP;
         end
         bfha_pkg::S_ASPLIT: begin
            if (rem != '0) state_in = bfha_pkg::S_AFOOT;
            else           state_in = bfha_pkg::S_AEXACT;
         end
         bfha_pkg::S_AFOOT, bfha_pkg::S_AEXACT: begin
            rfail_in = 1'b0;
            raddr_in = 12'(best_ff + ADDR_W'(4));
            state_in = bfha_pkg::S_RESP;
         end
         bfha_pkg::S_FWALK_RD: begin
            if ((ADDR_W+1)'(addr_ff) + (ADDR_W+1)'(4) <= (ADDR_W+1)'(limit_ff))
               state_in = bfha_pkg::S_FWALK_EV;
            else
               state_in = bfha_pkg::S_RESP;
         end
         bfha_pkg::S_FWALK_EV: begin
            if (hsize == '0) begin
               state_in = bfha_pkg::S_RESP;
            end else if (addr_ff == tgt_ff) begin
               size_in  = hsize;
               total_in = hsize;
               start_in = tgt_ff;
               hbit_in  = rd_val[1];
               if (!rd_val[0])      state_in = bfha_pkg::S_RESP;
               else if (!rd_val[1]) state_in = bfha_pkg::S_FPREV_RD;
               else                 state_in = bfha_pkg::S_FNEXT_RD;
            end else begin
               addr_in  = addr_ff + hsize;
               state_in = bfha_pkg::S_FWALK_RD;
            end
         end
         bfha_pkg::S_FPREV_RD: state_in = bfha_pkg::S_FPREV_EV;
         bfha_pkg::S_FPREV_EV: begin
            start_in = tgt_ff - hsize;
            total_in = total_ff + hsize;
            state_in = bfha_pkg::S_FNEXT_RD;
         end
         bfha_pkg::S_FNEXT_RD: state_in = bfha_pkg::S_FNEXT_EV;
         bfha_pkg::S_FNEXT_EV: begin
            if (nsize != '0 && !rd_val[0])
               total_in = total_ff + nsize;
            if (start_ff == tgt_ff) state_in = bfha_pkg::S_FHDR;
            else                    state_in = bfha_pkg::S_FSTART_RD;
         end
         bfha_pkg::S_FSTART_RD: state_in = bfha_pkg::S_FSTART_EV;
         bfha_pkg::S_FSTART_EV: state_in = bfha_pkg::S_FFOOT;
         bfha_pkg::S_FHDR:      state_in = bfha_pkg::S_FFOOT;
         bfha_pkg::S_FFOOT: begin
            rfail_in = 1'b0;
            state_in = bfha_pkg::S_RESP;
         end
         bfha_pkg::S_RESP: begin
            if (rsp_free) state_in = bfha_pkg::S_IDLE;
         end
         default: state_in = bfha_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == bfha_pkg::S_IDLE);
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = '0;
      mem_wdata = '0;
      unique case (state_ff)
         bfha_pkg::S_INIT_HDR: begin
            mem_we    = 1'b1;
            mem_addr  = ADDR_W'(4);
            mem_wdata = 32'(size_ff) | 32'd2;
         end
         bfha_pkg::S_INIT_END: begin
            mem_we    = 1'b1;
            mem_addr  = size_ff + ADDR_W'(4);
            mem_wdata = 32'd1;
         end
         bfha_pkg::S_INIT_FOOT: begin
            mem_we    = 1'b1;
            mem_addr  = size_ff;
            mem_wdata = 32'(size_ff);
         end
         bfha_pkg::S_AWALK_RD, bfha_pkg::S_FWALK_RD: begin
            mem_re   = 1'b1;
            mem_addr = addr_ff;
         end
         bfha_pkg::S_AFIN: begin
            mem_we    = found_ff;
            mem_addr  = best_ff;
            mem_wdata = 32'(need_ff) | 32'd1 | (bprev_ff ? 32'd2 : 32'd0);
         end
         bfha_pkg::S_ASPLIT: begin
            if (rem != '0) begin
               mem_we    = 1'b1;
               mem_addr  = best_ff + need_ff[ADDR_W-1:0];
               mem_wdata = 32'(rem) | 32'd2;
            end else begin
               mem_re   = 1'b1;
               mem_addr = best_ff + bsz_ff;
            end
         end
         bfha_pkg::S_AFOOT: begin
            mem_we    = 1'b1;
            mem_addr  = best_ff + bsz_ff - ADDR_W'(4);
            mem_wdata = 32'(rem);
         end
         bfha_pkg::S_AEXACT: begin
            mem_we    = 1'b1;
            mem_addr  = best_ff + bsz_ff;
            mem_wdata = rd_val | 32'd2;
         end
         bfha_pkg::S_FPREV_RD: begin
            mem_re   = 1'b1;
            mem_addr = tgt_ff - ADDR_W'(4);
         end
         bfha_pkg::S_FNEXT_RD: begin
            mem_re   = 1'b1;
            mem_addr = tgt_ff + size_ff;
         end
         bfha_pkg::S_FNEXT_EV: begin
            mem_we    = 1'b1;
            mem_addr  = tgt_ff + size_ff;
            mem_wdata = rd_val & ~32'd2;
         end
         bfha_pkg::S_FSTART_RD: begin
            mem_re   = 1'b1;
            mem_addr = start_ff;
         end
         bfha_pkg::S_FSTART_EV: begin
            mem_we    = 1'b1;
            mem_addr  = start_ff;
            mem_wdata = 32'(total_ff) | (rd_val & 32'd2);
         end
         bfha_pkg::S_FHDR: begin
            mem_we    = 1'b1;
            mem_addr  = tgt_ff;
            mem_wdata = 32'(total_ff) | (hbit_ff ? 32'd2 : 32'd0);
         end
         bfha_pkg::S_FFOOT: begin
            mem_we    = 1'b1;
            mem_addr  = start_ff + total_ff - ADDR_W'(4);
            mem_wdata = 32'(total_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we && mem_in_range)
         mem[mem_addr[WAW+1:2]] <= mem_wdata;
      if (mem_re)
         rd_q <= mem[mem_addr[WAW+1:2]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfha_pkg::S_IDLE;
         csr_ff       <= bfha_pkg::REGION_RESET;
         ready_ff     <= 1'b0;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         limit_ff <= limit_in;
         if (csr_we)
            csr_ff <= csr_wdata;
         if (state_ff == bfha_pkg::S_RESP && rsp_free)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re)
         rd_oob_ff <= !mem_in_range;
      addr_ff  <= addr_in;
      best_ff  <= best_in;
      bsz_ff   <= bsz_in;
      found_ff <= found_in;
      prev_ff  <= prev_in;
      bprev_ff <= bprev_in;
      need_ff  <= need_in;
      tgt_ff   <= tgt_in;
      size_ff  <= size_in;
      hbit_ff  <= hbit_in;
      start_ff <= start_in;
      total_ff <= total_in;
      rfail_ff <= rfail_in;
      raddr_ff <= raddr_in;
      if (state_ff == bfha_pkg::S_RESP && rsp_free) begin
         rsp_ff.fail        <= rfail_ff;
         rsp_ff.result_addr <= raddr_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[hdl/bfha_checker.sv]
// ----------------------------------------------------------------------------
// bfha_checker
// Port-level checks for the best-fit heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bfha_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire bfha_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fail |-> rsp_data.result_addr == 12'd0)
      else $error("failed response carries an address");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

endmodule

bind best_fit_heap_allocator bfha_checker u_bfha_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the best-fit heap allocator against its own heap predictor: region
// setup and init failures, then directed and random allocate/free traffic
// with random idle gaps on both the request and the response side.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   localparam int HEAP_WORDS = bfha_pkg::HEAP_BYTES_DEF / 4;
   localparam int PAGE       = bfha_pkg::PAGE_BYTES_DEF;
   localparam int CYCLE_CAP  = 4000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   bfha_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   bfha_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [bfha_pkg::REGION_W-1:0] csr_wdata = '0;

   best_fit_heap_allocator i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // heap predictor state
   logic [31:0] heap_mem [HEAP_WORDS];
   bit heap_on;
   int unsigned heap_top;
   int unsigned region_cfg;
   int unsigned live_blocks[$];

   bfha_pkg::req_type pending[$];
   bfha_pkg::rsp_type expected_rsp[$];
   int errors;
   int cycles;
   bit calm;

   function automatic logic [31:0] word_at(int unsigned addr);
      return ((addr >> 2) < HEAP_WORDS) ? heap_mem[addr >> 2] : 32'd0;
   endfunction

   function automatic void word_put(int unsigned addr, logic [31:0] v);
      if ((addr >> 2) < HEAP_WORDS)
         heap_mem[addr >> 2] = v;
   endfunction

   function automatic bit heap_format();
      int unsigned rounded, body;
      if (heap_on || region_cfg == 0)
         return 0;
      rounded = ((region_cfg + PAGE - 1) / PAGE) * PAGE;
      if (rounded > bfha_pkg::HEAP_BYTES_DEF || rounded < 8)
         return 0;
      for (int i = 0; i < HEAP_WORDS; i++)
         heap_mem[i] = 32'd0;
      body = rounded - 8;
      word_put(4, body | 2);
      word_put(4 + body, 1);
      word_put(body, body);
      heap_top = rounded;
      heap_on = 1;
      return 1;
   endfunction

   function automatic bit heap_alloc(int unsigned bytes, output int unsigned payload);
      int unsigned need, addr, best, best_size, rem, hdr, bsize;
      bit found, prev_alloc, best_prev;
      payload = 0;
      best = 0;
      best_size = 0;
      found = 0;
      prev_alloc = 1;
      best_prev = 1;
      if (!heap_on || bytes == 0)
         return 0;
      need = (bytes + 11) & ~32'd7;
      addr = 4;
      while (addr + 4 <= heap_top) begin
         hdr = word_at(addr);
         bsize = hdr & ~32'd3;
         if (bsize == 0)
            break;
         if (hdr[0]) begin
            prev_alloc = 1;
         end else begin
            if (bsize >= need && (!found || bsize < best_size)) begin
               found = 1;
               best = addr;
               best_size = bsize;
               best_prev = prev_alloc;
            end
            prev_alloc = 0;
         end
         addr += bsize;
      end
      if (!found)
         return 0;
      word_put(best, need | 1 | (best_prev ? 2 : 0));
      rem = best_size - need;
      if (rem != 0) begin
         word_put(best + need, rem | 2);
         word_put(best + need + rem - 4, rem);
      end else begin
         word_put(best + best_size, word_at(best + best_size) | 2);
      end
      payload = best + 4;
      return 1;
   endfunction

   function automatic bit heap_release(int unsigned paddr);
      int unsigned target, addr, hdr, bsize, size, start, total, nxt, nh, psize;
      bit hit;
      hit = 0;
      if (!heap_on || paddr == 0 || (paddr & 7) != 0)
         return 0;
      target = paddr - 4;
      addr = 4;
      while (addr + 4 <= heap_top) begin
         bsize = word_at(addr) & ~32'd3;
         if (bsize == 0)
            break;
         if (addr == target) begin
            hit = 1;
            break;
         end
         addr += bsize;
      end
      if (!hit)
         return 0;
      hdr = word_at(target);
      if (!hdr[0])
         return 0;
      size = hdr & ~32'd3;
      start = target;
      total = size;
      if (!hdr[1]) begin
         psize = word_at(target - 4) & ~32'd3;
         start = target - psize;
         total += psize;
      end
      nxt = target + size;
      nh = word_at(nxt) & ~32'd2;
      word_put(nxt, nh);
      if ((nh & ~32'd3) != 0 && !nh[0])
         total += nh & ~32'd3;
      if (start == target)
         word_put(start, total | (hdr & 2));
      else
         word_put(start, total | (word_at(start) & 2));
      word_put(start + total - 4, total);
      return 1;
   endfunction

   function automatic bfha_pkg::rsp_type heap_predict(bfha_pkg::req_type r);
      bfha_pkg::rsp_type o;
      int unsigned pay;
      bit ok;
      pay = 0;
      ok = 0;
      case (r.req_type)
         bfha_pkg::REQ_ALLOC: begin
            ok = heap_alloc(r.alloc_bytes, pay);
            if (ok)
               live_blocks.push_back(pay);
         end
         bfha_pkg::REQ_FREE: begin
            ok = heap_release(r.free_addr);
            if (ok)
               foreach (live_blocks[i])
                  if (live_blocks[i] == r.free_addr) begin
                     live_blocks.delete(i);
                     break;
                  end
         end
         bfha_pkg::REQ_INIT: ok = heap_format();
         default: ok = 0;
      endcase
      o.fail = !ok;
      o.result_addr = ok ? pay[11:0] : 12'd0;
      return o;
   endfunction

   function automatic int pick_gap();
      int p;
      if (calm)
         return 0;
      p = $urandom_range(99);
      if (p < 60)
         return 0;
      if (p < 92)
         return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // request driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_rsp.push_back(heap_predict(req_data));
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending.size() != 0) begin
               req_data <= pending.pop_front();
               req_valid <= 1'b1;
               req_gap <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   int rsp_gap = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("status: fail");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected response", rsp_data, 0);
            end else begin
               bfha_pkg::rsp_type e;
               e = expected_rsp.pop_front();
               if (rsp_data.fail !== e.fail)
                  report_mismatch("fail", rsp_data.fail, e.fail);
               if (rsp_data.result_addr !== e.result_addr)
                  report_mismatch("result_addr", rsp_data.result_addr, e.result_addr);
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_valid && rsp_ready)
               rsp_gap <= pick_gap();
         end
      end
   end

   task automatic send(bfha_pkg::op_type op, int unsigned bytes, int unsigned addr);
      bfha_pkg::req_type r;
      r.req_type = op;
      r.alloc_bytes = bytes[15:0];
      r.free_addr = addr[11:0];
      pending.push_back(r);
      while (pending.size() != 0)
         @(posedge clock);
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending.size() != 0 || expected_rsp.size() != 0 || req_valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_region(int unsigned v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v[bfha_pkg::REGION_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      region_cfg = v;
   endtask

   task automatic random_request();
      int p;
      p = $urandom_range(99);
      if (p < 50) begin
         p = $urandom_range(99);
         if (p < 70)
            send(bfha_pkg::REQ_ALLOC, $urandom_range(120, 1), 0);
         else if (p < 92)
            send(bfha_pkg::REQ_ALLOC, $urandom_range(700, 121), 0);
         else
            send(bfha_pkg::REQ_ALLOC, $urandom_range(65535), 0);
      end else if (p < 88 && live_blocks.size() != 0) begin
         send(bfha_pkg::REQ_FREE, 0, live_blocks[$urandom_range(live_blocks.size() - 1)]);
      end else if (p < 94) begin
         send(bfha_pkg::REQ_FREE, 0, $urandom_range(511) * 8);
      end else if (p < 98) begin
         send(bfha_pkg::REQ_FREE, 0, $urandom_range(4095));
      end else begin
         send(p[0] ? bfha_pkg::REQ_INIT : bfha_pkg::REQ_NONE, $urandom_range(65535),
              $urandom_range(4095));
      end
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      calm = 0;
      heap_on = 0;
      heap_top = 0;
      region_cfg = bfha_pkg::REGION_RESET;
      for (int i = 0; i < HEAP_WORDS; i++)
         heap_mem[i] = 32'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_region(0);
      send(bfha_pkg::REQ_ALLOC, 16, 0);
      send(bfha_pkg::REQ_FREE, 0, 8);
      send(bfha_pkg::REQ_INIT, 0, 0);
      send(bfha_pkg::REQ_NONE, 65535, 4095);
      drain();
      write_region(8191);
      send(bfha_pkg::REQ_INIT, 0, 0);
      drain();
      write_region(4097);
      send(bfha_pkg::REQ_INIT, 0, 0);
      drain();
      write_region(2900);
      send(bfha_pkg::REQ_INIT, 0, 0);
      send(bfha_pkg::REQ_INIT, 0, 0);
      send(bfha_pkg::REQ_ALLOC, 0, 0);
      send(bfha_pkg::REQ_ALLOC, 65535, 0);
      send(bfha_pkg::REQ_FREE, 0, 0);
      send(bfha_pkg::REQ_FREE, 0, 4095);
      send(bfha_pkg::REQ_ALLOC, 1, 0);
      send(bfha_pkg::REQ_ALLOC, 100, 0);
      send(bfha_pkg::REQ_ALLOC, 28, 0);
      send(bfha_pkg::REQ_FREE, 0, 16);
      send(bfha_pkg::REQ_FREE, 0, 8);
      send(bfha_pkg::REQ_FREE, 0, 8);
      send(bfha_pkg::REQ_ALLOC, 4, 0);
      send(bfha_pkg::REQ_ALLOC, 4, 0);
      send(bfha_pkg::REQ_FREE, 0, 4088);
      send(bfha_pkg::REQ_ALLOC, 3000, 0);
      send(bfha_pkg::REQ_NONE, 0, 0);
      drain();
      write_region(8);

      for (int ph = 0; ph < 6; ph++) begin
         calm = (ph == 2);
         for (int k = 0; k < 90; k++)
            random_request();
         drain();
         if (ph == 3)
            write_region($urandom_range(8191));
      end
      while (live_blocks.size() != 0) begin
         send(bfha_pkg::REQ_FREE, 0, live_blocks[0]);
         drain();
      end
      send(bfha_pkg::REQ_ALLOC, 3000, 0);
      drain();
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
